### hdl/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising clock edge outside reset
`define IPP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define IPP_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define IPP_ASSERT(name, clk, rst_n, prop, msg)
`define IPP_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

### hdl/ipp_pkg.sv
// Types and constants for the IMU FIFO packet parser.
// No dependencies; used by the stream interfaces and the top level.
`default_nettype none

package ipp_pkg;

    // Width of the FIFO byte counter
    localparam int COUNT_BITS = 16;
    localparam int PCOUNT_W   = 16;
    localparam int LIMIT_W    = 16;
    localparam int PIDX_W     = 4;
    localparam int SIZE_W     = 5;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_PACKET_LIMIT = '0;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = 16'd64;

    // Beat modes
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    // Header bit positions
    localparam int HDR_MSG_BIT   = 7;
    localparam int HDR_ACCEL_BIT = 6;
    localparam int HDR_GYRO_BIT  = 5;
    localparam int HDR_20BIT_BIT = 4;

    // Packet sizes, header byte included
    localparam logic [SIZE_W-1:0] BOTH_BYTES = 5'd16;
    localparam logic [SIZE_W-1:0] ONE_BYTES  = 5'd8;
    localparam logic [PIDX_W-1:0] AXIS_BYTES  = 4'd6;
    localparam logic [PIDX_W-1:0] STAMP_BYTES = 4'd2;
    // Payload index of the last byte of a packet
    localparam logic [PIDX_W-1:0] LAST_BOTH = PIDX_W'(BOTH_BYTES - 5'd2);
    localparam logic [PIDX_W-1:0] LAST_ONE  = PIDX_W'(ONE_BYTES - 5'd2);

    typedef enum logic [1:0] {
        PH_DONE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_PACKET  = 2'd0,
        ST_MSG     = 2'd1,
        ST_SHORT   = 2'd2,
        ST_BAD_HDR = 2'd3
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] available_bytes;
        logic [7:0]  data_byte;
    } in_beat_t;

    typedef struct packed {
        status_t            status;
        logic [1:0]         sensors;
        logic               stamp_valid;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [7:0]  temperature;
        logic [15:0]        timestamp;
        logic [15:0]        packet_count;
    } out_beat_t;

endpackage

`default_nettype wire

### hdl/ipp_in_if.sv
// Valid/ready channel carrying FIFO bytes and read-begin beats.
// Depends on ipp_pkg for the beat type.
`default_nettype none

interface ipp_in_if import ipp_pkg::*;;

    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### hdl/ipp_out_if.sv
// Valid/ready channel carrying parsed packet results.
// Depends on ipp_pkg for the beat type.
`default_nettype none

interface ipp_out_if import ipp_pkg::*;;

    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### hdl/imu_fifo_packet_parser.sv
// IMU FIFO packet parser: one input beat per cycle while the result register is free, at most one result beat each.
// Latency: a result is valid on the cycle after the beat that causes it is accepted.
// Throughput: one beat per cycle; the single result register frees itself when
// the sink takes it, so input ready only drops while a result waits and sink is stalled.
// Reset: packet_limit returns to 64 and the parser ignores FIFO bytes until a begin beat.
// Depends on ipp_pkg, ipp_in_if, ipp_out_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module imu_fifo_packet_parser import ipp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    ipp_in_if.sink                     byte_stream,
    ipp_out_if.source                  packet_stream
);

    // State
    logic [LIMIT_W-1:0]    packet_limit_reg;
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [PCOUNT_W-1:0]   packets_done_reg, packets_done_next;
    logic [1:0]            sensors_reg, sensors_next;     // bit0 accel, bit1 gyro
    logic [PIDX_W-1:0]     payload_index_reg, payload_index_next;
    logic [15:0]           accel_hold_reg [3];
    logic [15:0]           accel_hold_next [3];
    logic [15:0]           gyro_hold_reg [3];
    logic [15:0]           gyro_hold_next [3];
    logic [7:0]            temp_hold_reg, temp_hold_next;
    logic [15:0]           stamp_hold_reg, stamp_hold_next;
    out_beat_t             out_beat_reg, out_beat_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload byte steering
    logic [15:0]           accel_upd [3];
    logic [15:0]           gyro_upd [3];
    logic [7:0]            temp_upd;
    logic [15:0]           stamp_upd;
    logic                  acc_wr, gyr_wr, temp_wr, stamp_wr;
    logic [PIDX_W-1:0]     pos_gyr, pos_tail;

    logic                  beat_ok;
    logic                  emit;
    logic [7:0]            b;
    logic                  acc, gyr, both;
    logic                  hdr_both;
    logic [SIZE_W-1:0]     hdr_size, pkt_size;
    logic [COUNT_BITS-1:0] avail;
    logic [COUNT_BITS-1:0] bytes_after;
    logic [PCOUNT_W-1:0]   count_after;
    logic                  last_byte;
    logic                  cfg_wr;

    assign b       = byte_stream.data.data_byte;
    assign avail   = byte_stream.data.available_bytes[COUNT_BITS-1:0];
    assign acc     = sensors_reg[0];
    assign gyr     = sensors_reg[1];
    assign both    = acc && gyr;
    assign beat_ok = byte_stream.valid && byte_stream.ready;

    // Handshakes: result register frees when the sink takes it
    assign byte_stream.ready   = !out_valid_reg || packet_stream.ready;
    assign packet_stream.valid = out_valid_reg;
    assign packet_stream.data  = out_beat_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[PADDR_W-1:2] == REG_PACKET_LIMIT);

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_PACKET_LIMIT)
        begin
            prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, packet_limit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            packet_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Where the current payload byte lands: accel axes, gyro axes, temp, stamp
    always_comb
    begin
        acc_wr   = 1'b0;
        gyr_wr   = 1'b0;
        temp_wr  = 1'b0;
        stamp_wr = 1'b0;
        pos_gyr  = payload_index_reg;
        pos_tail = payload_index_reg;
        if (acc && payload_index_reg < AXIS_BYTES)
        begin
            acc_wr = 1'b1;
        end
        else
        begin
            pos_gyr = acc ? payload_index_reg - AXIS_BYTES : payload_index_reg;
            if (gyr && pos_gyr < AXIS_BYTES)
            begin
                gyr_wr = 1'b1;
            end
            else
            begin
                pos_tail = gyr ? pos_gyr - AXIS_BYTES : pos_gyr;
                if (pos_tail == '0)
                begin
                    temp_wr = 1'b1;
                end
                else if (both && pos_tail <= STAMP_BYTES)
                begin
                    stamp_wr = 1'b1;
                end
            end
        end
    end

    // Big-endian shift into the selected hold register
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            accel_upd[i] = (acc_wr && payload_index_reg[2:1] == 2'(i))
                           ? {accel_hold_reg[i][7:0], b} : accel_hold_reg[i];
            gyro_upd[i]  = (gyr_wr && pos_gyr[2:1] == 2'(i))
                           ? {gyro_hold_reg[i][7:0], b} : gyro_hold_reg[i];
        end
        temp_upd  = temp_wr ? b : temp_hold_reg;
        stamp_upd = stamp_wr ? {stamp_hold_reg[7:0], b} : stamp_hold_reg;
    end

    assign hdr_both    = b[HDR_ACCEL_BIT] && b[HDR_GYRO_BIT];
    assign hdr_size    = hdr_both ? BOTH_BYTES : ONE_BYTES;
    assign pkt_size    = both ? BOTH_BYTES : ONE_BYTES;
    assign last_byte   = payload_index_reg >= (both ? LAST_BOTH : LAST_ONE);
    assign bytes_after = bytes_left_reg - COUNT_BITS'(pkt_size);
    assign count_after = packets_done_reg + PCOUNT_W'(1);

    // Parser next state and result
    always_comb
    begin
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        packets_done_next  = packets_done_reg;
        sensors_next       = sensors_reg;
        payload_index_next = payload_index_reg;
        for (int i = 0; i < 3; i++)
        begin
            accel_hold_next[i] = accel_hold_reg[i];
            gyro_hold_next[i]  = gyro_hold_reg[i];
        end
        temp_hold_next  = temp_hold_reg;
        stamp_hold_next = stamp_hold_reg;
        emit            = 1'b0;
        out_beat_next   = '0;

        if (beat_ok)
        begin
            if (byte_stream.data.mode == MODE_BEGIN)
            begin
                bytes_left_next    = avail;
                packets_done_next  = '0;
                payload_index_next = '0;
                phase_next = (packet_limit_reg == '0 || avail == '0) ? PH_DONE : PH_HEADER;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (b[HDR_MSG_BIT])
                        begin
                            emit                       = 1'b1;
                            out_beat_next.status       = ST_MSG;
                            out_beat_next.packet_count = packets_done_reg;
                            phase_next                 = PH_DONE;
                        end
                        else if (b[HDR_20BIT_BIT] || !(b[HDR_ACCEL_BIT] || b[HDR_GYRO_BIT]))
                        begin
                            emit                       = 1'b1;
                            out_beat_next.status       = ST_BAD_HDR;
                            out_beat_next.packet_count = packets_done_reg;
                            phase_next                 = PH_DONE;
                        end
                        else if (COUNT_BITS'(hdr_size) > bytes_left_reg)
                        begin
                            emit                       = 1'b1;
                            out_beat_next.status       = ST_SHORT;
                            out_beat_next.packet_count = packets_done_reg;
                            phase_next                 = PH_DONE;
                        end
                        else
                        begin
                            sensors_next       = {b[HDR_GYRO_BIT], b[HDR_ACCEL_BIT]};
                            payload_index_next = '0;
                            for (int i = 0; i < 3; i++)
                            begin
                                accel_hold_next[i] = '0;
                                gyro_hold_next[i]  = '0;
                            end
                            temp_hold_next  = '0;
                            stamp_hold_next = '0;
                            phase_next      = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            accel_hold_next[i] = accel_upd[i];
                            gyro_hold_next[i]  = gyro_upd[i];
                        end
                        temp_hold_next  = temp_upd;
                        stamp_hold_next = stamp_upd;
                        if (last_byte)
                        begin
                            emit                        = 1'b1;
                            out_beat_next.status        = ST_PACKET;
                            out_beat_next.sensors       = sensors_reg;
                            out_beat_next.stamp_valid   = both;
                            out_beat_next.accel_x       = accel_upd[0];
                            out_beat_next.accel_y       = accel_upd[1];
                            out_beat_next.accel_z       = accel_upd[2];
                            out_beat_next.gyro_x        = gyro_upd[0];
                            out_beat_next.gyro_y        = gyro_upd[1];
                            out_beat_next.gyro_z        = gyro_upd[2];
                            out_beat_next.temperature   = temp_upd;
                            out_beat_next.timestamp     = both ? stamp_upd : '0;
                            out_beat_next.packet_count  = count_after;
                            bytes_left_next    = bytes_after;
                            packets_done_next  = count_after;
                            payload_index_next = '0;
                            phase_next = (count_after >= packet_limit_reg || bytes_after == '0)
                                         ? PH_DONE : PH_HEADER;
                        end
                        else
                        begin
                            payload_index_next = payload_index_reg + PIDX_W'(1);
                        end
                    end
                    default:
                    begin
                        // done: bytes are dropped
                    end
                endcase
            end
        end
    end

    // Result register valid
    always_comb
    begin
        if (beat_ok && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (packet_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_DONE;
            bytes_left_reg    <= '0;
            packets_done_reg  <= '0;
            sensors_reg       <= '0;
            payload_index_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            packets_done_reg  <= packets_done_next;
            sensors_reg       <= sensors_next;
            payload_index_reg <= payload_index_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload holds and result data
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            accel_hold_reg[i] <= accel_hold_next[i];
            gyro_hold_reg[i]  <= gyro_hold_next[i];
        end
        temp_hold_reg  <= temp_hold_next;
        stamp_hold_reg <= stamp_hold_next;
        if (beat_ok && emit)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    // Checks
    `IPP_ASSERT(a_index_range, clk, rst_n, (phase_reg == PH_PAYLOAD) |-> (payload_index_reg <= LAST_BOTH), "payload index past last byte")
    `IPP_ASSERT_NEVER(a_payload_sensors, clk, rst_n, (phase_reg == PH_PAYLOAD) && (sensors_reg == 2'b00), "payload phase with no sensor")
    `IPP_ASSERT(a_stop_empty, clk, rst_n, (out_valid_reg && out_beat_reg.status != ST_PACKET) |-> (out_beat_reg.sensors == 2'b00 && !out_beat_reg.stamp_valid && out_beat_reg.timestamp == '0), "stop result carries data")
    `IPP_ASSERT(a_packet_stamp, clk, rst_n, (out_valid_reg && out_beat_reg.status == ST_PACKET) |-> (out_beat_reg.sensors != 2'b00 && out_beat_reg.stamp_valid == (out_beat_reg.sensors == 2'b11)), "packet sensors and timestamp flag disagree")
    `IPP_ASSERT(a_begin_phase, clk, rst_n, (beat_ok && byte_stream.data.mode == MODE_BEGIN) |=> (phase_reg != PH_PAYLOAD && payload_index_reg == '0), "begin beat left a packet open")

endmodule

`default_nettype wire
